// ----- rtl/sdms_pkg.sv -----
// ----------------------------------------------------------------------------
// sdms_pkg
// Shared constants, register codes and types of the second-difference
// magnitude stencil.
// ----------------------------------------------------------------------------
package sdms_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_X        = 64;
    localparam int MAX_Y        = 64;
    localparam int MAX_Z        = 64;

    localparam int DW       = SAMPLE_WIDTH + 3;   // signed stencil sum
    localparam int MW       = SAMPLE_WIDTH + 2;   // magnitude of a stencil sum
    localparam int HW       = (MW + 1) / 2;       // low half for partial products
    localparam int RW       = 35;                 // root width
    localparam int SQW      = 2 * RW;             // radicand width
    localparam int MEANW    = 36;
    localparam int CW       = 6;                  // cell index width
    localparam int SZW      = 7;                  // size register width
    localparam int PLANE_AW = $clog2(MAX_X * MAX_Y);
    localparam int ROW_AW   = $clog2(MAX_X);
    localparam int QDEPTH   = 4;
    localparam int NTAPS    = 7;

    typedef enum logic [2:0] {
        REG_DIMENSIONS  = 3'd0,
        REG_SIZE_X      = 3'd1,
        REG_SIZE_Y      = 3'd2,
        REG_SIZE_Z      = 3'd3,
        REG_MEAN_ENABLE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]     dims;
        logic [SZW-1:0] size_x;
        logic [SZW-1:0] size_y;
        logic [SZW-1:0] size_z;
        logic           mean_en;
    } t_cfg;

    typedef struct packed {
        logic [1:0]    dims;
        logic          mean_en;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] cz;
        logic          last;
    } t_cell_meta;

    typedef struct packed {
        logic [NTAPS-1:0][SAMPLE_WIDTH-1:0] taps;
        t_cell_meta                         info;
    } t_qent;

    typedef struct packed {
        t_cell_meta              info;
        logic signed [MEANW-1:0] mean1d;
    } t_back_meta;

endpackage

// ----- rtl/sdms_delay.sv -----
// ----------------------------------------------------------------------------
// sdms_delay
// Sample delay line of run-time length (0 .. 2**AW-1) on a ring memory.
// ----------------------------------------------------------------------------
module sdms_delay
    import sdms_pkg::*;
#(
    parameter int AW = ROW_AW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [AW-1:0]           i_len,
    input  logic [SAMPLE_WIDTH-1:0] i_din,
    output logic [SAMPLE_WIDTH-1:0] o_dout
);

    logic [SAMPLE_WIDTH-1:0] r_mem [2**AW];
    logic [SAMPLE_WIDTH-1:0] r_q;
    logic [AW-1:0]           r_wptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
        end else if (i_en) begin
            r_wptr <= r_wptr + AW'(1);
        end
    end

    // read the entry that becomes due at the next transfer
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[r_wptr] <= i_din;
            if (i_len == AW'(1)) begin
                r_q <= i_din;
            end else begin
                r_q <= r_mem[r_wptr - i_len + AW'(1)];
            end
        end
    end

    assign o_dout = (i_len == '0) ? i_din : r_q;

endmodule

// ----- rtl/sdms_front.sv -----
// ----------------------------------------------------------------------------
// sdms_front
// Grid position tracking, stencil tap delay chain and cell classification.
// ----------------------------------------------------------------------------
module sdms_front
    import sdms_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_restart,
    input  logic                    i_accept,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_push,
    output t_qent                   o_ent
);

    logic [1:0]          dims;
    logic [SZW-1:0]      sx, sy, sz;
    logic [PLANE_AW-1:0] len_a;
    logic [ROW_AW-1:0]   len_b;
    logic [SAMPLE_WIDTH-1:0] t0, t1, t2, t5, t6;
    logic [SAMPLE_WIDTH-1:0] r_t3, r_t4;
    logic [CW-1:0]       r_pos_x, r_pos_y, r_pos_z;
    logic [SZW-1:0]      px, py, pz, nx, ny, nz;
    logic [2*SZW-1:0]    plane_less_row;
    logic                emit, last;
    logic [CW-1:0]       cx, cy, cz;

    always_comb begin
        dims = (i_cfg.dims == 2'd0) ? 2'd1 : i_cfg.dims;
        sx = (i_cfg.size_x < SZW'(3)) ? SZW'(3) :
             (i_cfg.size_x > SZW'(MAX_X)) ? SZW'(MAX_X) : i_cfg.size_x;
        sy = (i_cfg.size_y < SZW'(1)) ? SZW'(1) :
             (i_cfg.size_y > SZW'(MAX_Y)) ? SZW'(MAX_Y) : i_cfg.size_y;
        sz = (i_cfg.size_z < SZW'(1)) ? SZW'(1) :
             (i_cfg.size_z > SZW'(MAX_Z)) ? SZW'(MAX_Z) : i_cfg.size_z;
        plane_less_row = sx * (sy - SZW'(1));
        len_a = (dims == 2'd3) ? plane_less_row[PLANE_AW-1:0] : '0;
        len_b = (dims >= 2'd2) ? ROW_AW'(sx - SZW'(1)) : '0;
    end

    // taps: 0 newest, 3 centre; x pair 2/4, y pair 1/5, z pair 0/6
    assign t0 = i_sample;

    sdms_delay #(.AW(PLANE_AW)) u_dly_a0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_accept), .i_len(len_a),
        .i_din(t0), .o_dout(t1)
    );
    sdms_delay #(.AW(ROW_AW)) u_dly_b0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_accept), .i_len(len_b),
        .i_din(t1), .o_dout(t2)
    );
    sdms_delay #(.AW(ROW_AW)) u_dly_b1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_accept), .i_len(len_b),
        .i_din(r_t4), .o_dout(t5)
    );
    sdms_delay #(.AW(PLANE_AW)) u_dly_a1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_accept), .i_len(len_a),
        .i_din(t5), .o_dout(t6)
    );

    always_comb begin
        px = {1'b0, r_pos_x};
        py = {1'b0, r_pos_y};
        pz = {1'b0, r_pos_z};
        nx = px + SZW'(1);
        ny = py + SZW'(1);
        nz = pz + SZW'(1);
        emit = 1'b0;
        last = 1'b0;
        cx = '0;
        cy = '0;
        cz = '0;
        unique case (dims)
            2'd1: begin
                emit = (px >= SZW'(2));
                cx   = r_pos_x - CW'(1);
                last = (px == sx - SZW'(1));
            end
            2'd2: begin
                emit = (py >= SZW'(2)) && (px >= SZW'(1)) && (px + SZW'(2) <= sx);
                cx   = r_pos_x;
                cy   = r_pos_y - CW'(1);
                last = (px == sx - SZW'(2)) && (py == sy - SZW'(1));
            end
            default: begin
                emit = (pz >= SZW'(2)) && (px >= SZW'(1)) && (px + SZW'(2) <= sx)
                    && (py >= SZW'(1)) && (py + SZW'(2) <= sy);
                cx   = r_pos_x;
                cy   = r_pos_y;
                cz   = r_pos_z - CW'(1);
                last = (px == sx - SZW'(2)) && (py == sy - SZW'(2))
                    && (pz == sz - SZW'(1));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_t3    <= '0;
            r_t4    <= '0;
        end else if (i_restart) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else if (i_accept) begin
            r_t3 <= t2;
            r_t4 <= r_t3;
            if (nx >= sx) begin
                r_pos_x <= '0;
                if (dims >= 2'd2 && ny < sy) begin
                    r_pos_y <= ny[CW-1:0];
                end else begin
                    r_pos_y <= '0;
                    if (dims == 2'd3 && nz < sz) begin
                        r_pos_z <= nz[CW-1:0];
                    end else begin
                        r_pos_z <= '0;
                    end
                end
            end else begin
                r_pos_x <= nx[CW-1:0];
            end
        end
    end

    assign o_push            = i_accept && emit;
    assign o_ent.taps        = {t6, t5, r_t4, r_t3, t2, t1, t0};
    assign o_ent.info.dims   = dims;
    assign o_ent.info.mean_en = i_cfg.mean_en;
    assign o_ent.info.cx     = cx;
    assign o_ent.info.cy     = cy;
    assign o_ent.info.cz     = cz;
    assign o_ent.info.last   = last;

endmodule

// ----- rtl/sdms_fifo.sv -----
// ----------------------------------------------------------------------------
// sdms_fifo
// Short queue of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module sdms_fifo
    import sdms_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_din,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_qent o_dout
);

    localparam int AW = $clog2(DEPTH);

    t_qent         r_ent [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_din;
        end
    end

    assign o_full     = (r_count == (AW+1)'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_dout     = r_ent[r_rptr];

endmodule

// ----- rtl/sdms_isqrt.sv -----
// ----------------------------------------------------------------------------
// sdms_isqrt
// Pipelined floored integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sdms_isqrt
    import sdms_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [SQW-1:0] i_rad,
    output logic [RW-1:0]  o_root
);

    logic [SQW-1:0] r_op  [RW];
    logic [SQW-1:0] r_res [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [SQW-1:0] op_in, res_in, one, trial;

        assign op_in  = (k == 0) ? i_rad : r_op[(k == 0) ? 0 : k - 1];
        assign res_in = (k == 0) ? '0 : r_res[(k == 0) ? 0 : k - 1];
        assign one    = SQW'(1) << (2 * (RW - 1 - k));
        assign trial  = res_in + one;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (op_in >= trial) begin
                    r_op[k]  <= op_in - trial;
                    r_res[k] <= (res_in >> 1) + one;
                end else begin
                    r_op[k]  <= op_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[RW-1][RW-1:0];

endmodule

// ----- rtl/sdms_back.sv -----
// ----------------------------------------------------------------------------
// sdms_back
// Stencil arithmetic: second differences and means, squares, sums, roots,
// and the output register.
// ----------------------------------------------------------------------------
module sdms_back
    import sdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  t_qent             i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RW-1:0]     o_diff,
    output logic [MEANW-1:0]  o_mean,
    output logic              o_mean_valid,
    output logic [CW-1:0]     o_cx,
    output logic [CW-1:0]     o_cy,
    output logic [CW-1:0]     o_cz,
    output logic              o_last
);

    localparam int NL  = 3 + RW;
    localparam int PPW = 2 * HW;

    logic              en;
    logic [MW-1:0]     dmag [3];
    logic [MW-1:0]     mmag [3];
    logic signed [MEANW-1:0] mean1d;
    logic [MW-1:0]     r_dmag [3];
    logic [MW-1:0]     r_mmag [3];
    logic [PPW-1:0]    r_pp [6][3];
    logic [SQW-1:0]    r_dsum, r_msum;
    logic [SQW-1:0]    dsum, msum;
    t_back_meta        r_meta [NL];
    logic [NL-1:0]     r_mv;
    logic [RW-1:0]     droot, mroot;

    assign en    = !r_mv[NL-1] || i_ready;
    assign o_pop = en && i_nonempty;

    always_comb begin
        logic signed [DW-1:0] c, r, l, d, m;
        logic active;
        c = DW'($signed(i_head.taps[3]));
        mean1d = '0;
        for (int a = 0; a < 3; a++) begin
            r = DW'($signed(i_head.taps[2 - a]));
            l = DW'($signed(i_head.taps[4 + a]));
            d = r + l - (c <<< 1);
            m = r + l + (c <<< 1);
            active = (a == 0) || (a == 1 && i_head.info.dims >= 2'd2)
                || (a == 2 && i_head.info.dims == 2'd3);
            dmag[a] = !active ? '0 : d[DW-1] ? MW'(-d) : MW'(d);
            mmag[a] = !active ? '0 : m[DW-1] ? MW'(-m) : MW'(m);
            if (a == 0) begin
                mean1d = MEANW'(m);
            end
        end
    end

    always_comb begin
        logic [SQW-1:0] sq;
        dsum = '0;
        msum = '0;
        for (int a = 0; a < 6; a++) begin
            sq = (SQW'(r_pp[a][0]) << (2 * HW)) + (SQW'(r_pp[a][1]) << (HW + 1))
                + SQW'(r_pp[a][2]);
            if (a < 3) begin
                dsum = dsum + sq;
            end else begin
                msum = msum + sq;
            end
        end
    end

    // split each magnitude into halves so the multipliers stay narrow
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] v;
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_dmag[a] <= dmag[a];
                r_mmag[a] <= mmag[a];
            end
            for (int a = 0; a < 6; a++) begin
                v = (a < 3) ? r_dmag[a % 3] : r_mmag[a % 3];
                r_pp[a][0] <= PPW'(v[MW-1:HW]) * PPW'(v[MW-1:HW]);
                r_pp[a][1] <= PPW'(v[MW-1:HW]) * PPW'(v[HW-1:0]);
                r_pp[a][2] <= PPW'(v[HW-1:0]) * PPW'(v[HW-1:0]);
            end
            r_dsum <= dsum;
            r_msum <= msum;
            r_meta[0].info   <= i_head.info;
            r_meta[0].mean1d <= mean1d;
            for (int s = 1; s < NL; s++) begin
                r_meta[s] <= r_meta[s - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (en) begin
            r_mv <= {r_mv[NL-2:0], i_nonempty};
        end
    end

    sdms_isqrt u_sqrt_diff (.i_clk(i_clk), .i_en(en), .i_rad(r_dsum), .o_root(droot));
    sdms_isqrt u_sqrt_mean (.i_clk(i_clk), .i_en(en), .i_rad(r_msum), .o_root(mroot));

    assign o_valid      = r_mv[NL-1];
    assign o_diff       = droot;
    assign o_mean       = !r_meta[NL-1].info.mean_en ? '0 :
                          (r_meta[NL-1].info.dims == 2'd1) ? r_meta[NL-1].mean1d :
                          MEANW'(mroot);
    assign o_mean_valid = r_meta[NL-1].info.mean_en;
    assign o_cx         = r_meta[NL-1].info.cx;
    assign o_cy         = r_meta[NL-1].info.cy;
    assign o_cz         = r_meta[NL-1].info.cz;
    assign o_last       = r_meta[NL-1].info.last;

endmodule

// ----- rtl/second_difference_magnitude_stencil.sv -----
// ----------------------------------------------------------------------------
// second_difference_magnitude_stencil
// Second-difference norm and local mean over a 1D/2D/3D sample grid.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle and delivers one result per
// cycle for each interior cell; its input stalls only when the four-entry cell
// queue is full, which happens only after the output has been held. After its
// cell leaves the queue, a result passes three arithmetic stages and a
// 35-stage square-root pipeline, which all hold while the output is held.
// The stencil taps come from two plane delay memories and two row delay
// memories, one write and one read per accepted sample each; no clearing pass
// runs after reset. Any register write restarts the grid at cell zero.
module second_difference_magnitude_stencil
    import sdms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // diff_magnitude[34:0], mean_value[70:35], cell_x[76:71], cell_y[82:77],
    // cell_z[88:83], zero[95:89]
    output logic [95:0] m_tdata,
    output logic        m_tuser,   // mean_valid
    output logic        m_tlast
);

    t_cfg             r_cfg;
    logic             wr, restart, accept, push, full, pop, nonempty;
    t_qent            ent, head;
    logic [RW-1:0]    diff;
    logic [MEANW-1:0] mean;
    logic [CW-1:0]    cx, cy, cz;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims    <= 2'd3;
            r_cfg.size_x  <= SZW'(64);
            r_cfg.size_y  <= SZW'(64);
            r_cfg.size_z  <= SZW'(64);
            r_cfg.mean_en <= 1'b1;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_DIMENSIONS:  r_cfg.dims    <= pwdata[1:0];
                REG_SIZE_X:      r_cfg.size_x  <= pwdata[SZW-1:0];
                REG_SIZE_Y:      r_cfg.size_y  <= pwdata[SZW-1:0];
                REG_SIZE_Z:      r_cfg.size_z  <= pwdata[SZW-1:0];
                REG_MEAN_ENABLE: r_cfg.mean_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DIMENSIONS:  prdata = 32'(r_cfg.dims);
            REG_SIZE_X:      prdata = 32'(r_cfg.size_x);
            REG_SIZE_Y:      prdata = 32'(r_cfg.size_y);
            REG_SIZE_Z:      prdata = 32'(r_cfg.size_z);
            REG_MEAN_ENABLE: prdata = 32'(r_cfg.mean_en);
            default:         prdata = '0;
        endcase
    end

    // writes beyond the register list leave the grid position alone
    assign restart  = wr && (paddr[4:2] <= 3'(REG_MEAN_ENABLE));
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sdms_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_restart(restart),
        .i_accept(accept), .i_sample(s_tdata[SAMPLE_WIDTH-1:0]),
        .o_push(push), .o_ent(ent)
    );

    sdms_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_din(ent),
        .o_full(full), .i_pop(pop), .o_nonempty(nonempty), .o_dout(head)
    );

    sdms_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_nonempty(nonempty), .i_head(head),
        .o_pop(pop), .o_valid(m_tvalid), .i_ready(m_tready), .o_diff(diff),
        .o_mean(mean), .o_mean_valid(m_tuser), .o_cx(cx), .o_cy(cy), .o_cz(cz),
        .o_last(m_tlast)
    );

    assign m_tdata = {7'd0, cz, cy, cx, mean, diff};

endmodule

// ----- sim/second_difference_magnitude_stencil_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_difference_magnitude_stencil_checker
// Watches the register port and both streams, models the stencil on every
// accepted sample and compares each result transfer with the oldest expected
// cell result.
// ----------------------------------------------------------------------------
module second_difference_magnitude_stencil_checker
    import sdms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // sample[31:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // diff_magnitude[34:0], mean_value[70:35], cell_x[76:71], cell_y[82:77],
    // cell_z[88:83], zero[95:89]
    input  logic [95:0] i_m_tdata,
    input  logic        i_m_tuser,   // mean_valid
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int HIST_DEPTH = 2 * MAX_X * MAX_Y + 2;

    typedef struct {
        logic [34:0] diff_mag;
        logic [35:0] mean_val;
        logic        mean_vld;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [5:0]  cz;
        logic        last;
    } t_cell_result;

    t_cell_result expected_cells[$];

    logic signed [31:0] sample_hist[HIST_DEPTH];
    int unsigned        wr_ptr;
    int unsigned        pos_x, pos_y, pos_z;
    logic [1:0]         dims_r;
    logic [6:0]         size_x_r, size_y_r, size_z_r;
    logic               mean_en_r;
    int                 fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_cells.size();

    task automatic report_mismatch(input string what, input logic [71:0] got,
                                   input logic [71:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint hist_at(input int unsigned back);
        return longint'(sample_hist[(wr_ptr + HIST_DEPTH - back) % HIST_DEPTH]);
    endfunction

    // floored root of a^2 + b^2 + c^2
    function automatic logic [34:0] floor_norm(input longint a, input longint b,
                                                input longint c);
        logic [71:0] acc;
        logic [71:0] mag;
        logic [71:0] cand_sq;
        logic [34:0] root;
        logic [34:0] cand;
        longint      v[3];
        v[0] = a; v[1] = b; v[2] = c;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            mag = 72'(v[i] < 0 ? -v[i] : v[i]);
            acc += mag * mag;
        end
        root = '0;
        for (int bt = 34; bt >= 0; bt--) begin
            cand    = root | (35'd1 << bt);
            cand_sq = 72'(cand) * 72'(cand);
            if (cand_sq <= acc) root = cand;
        end
        return root;
    endfunction

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_cell(input logic [31:0] raw);
        int unsigned  dims, sx, sy, sz, plane, back_c, n;
        int unsigned  rb[3], lb[3];
        longint       d2[3], mn[3], cv, rv, lv;
        logic         emit, is_last;
        t_cell_result res;
        sample_hist[wr_ptr] = raw;
        dims  = dims_r == 2'd0 ? 1 : dims_r;
        sx    = clamp(size_x_r, 3, MAX_X);
        sy    = clamp(size_y_r, 1, MAX_Y);
        sz    = clamp(size_z_r, 1, MAX_Z);
        plane = sx * sy;
        emit  = 1'b0;
        is_last = 1'b0;
        n = 0; back_c = 0;
        res.cx = '0; res.cy = '0; res.cz = '0;
        for (int i = 0; i < 3; i++) begin
            rb[i] = 0; lb[i] = 0; d2[i] = 0; mn[i] = 0;
        end
        if (dims == 1) begin
            if (pos_x >= 2) begin
                emit = 1'b1; res.cx = 6'(pos_x - 1); back_c = 1;
                is_last = pos_x == sx - 1;
                n = 1; rb[0] = 0; lb[0] = 2;
            end
        end else if (dims == 2) begin
            if (pos_y >= 2 && pos_x >= 1 && pos_x + 2 <= sx) begin
                emit = 1'b1; res.cx = 6'(pos_x); res.cy = 6'(pos_y - 1); back_c = sx;
                is_last = pos_x == sx - 2 && pos_y == sy - 1;
                n = 2;
                rb[0] = sx - 1; lb[0] = sx + 1;
                rb[1] = 0;      lb[1] = 2 * sx;
            end
        end else begin
            if (pos_z >= 2 && pos_x >= 1 && pos_x + 2 <= sx &&
                pos_y >= 1 && pos_y + 2 <= sy) begin
                emit = 1'b1;
                res.cx = 6'(pos_x); res.cy = 6'(pos_y); res.cz = 6'(pos_z - 1);
                back_c = plane;
                is_last = pos_x == sx - 2 && pos_y == sy - 2 && pos_z == sz - 1;
                n = 3;
                rb[0] = plane - 1;  lb[0] = plane + 1;
                rb[1] = plane - sx; lb[1] = plane + sx;
                rb[2] = 0;          lb[2] = 2 * plane;
            end
        end
        if (emit) begin
            cv = hist_at(back_c);
            for (int i = 0; i < n; i++) begin
                rv = hist_at(rb[i]);
                lv = hist_at(lb[i]);
                d2[i] = rv + lv - 2 * cv;
                mn[i] = rv + lv + 2 * cv;
            end
            res.diff_mag = floor_norm(d2[0], d2[1], d2[2]);
            if (!mean_en_r)
                res.mean_val = '0;
            else if (n == 1)
                res.mean_val = mn[0][35:0];
            else
                res.mean_val = 36'(floor_norm(mn[0], mn[1], mn[2]));
            res.mean_vld = mean_en_r;
            res.last     = is_last;
            expected_cells.push_back(res);
        end
        // advance the raster position
        pos_x++;
        if (pos_x >= sx) begin
            pos_x = 0;
            pos_y++;
            if (!(dims >= 2 && pos_y < sy)) begin
                pos_y = 0;
                pos_z++;
                if (!(dims == 3 && pos_z < sz)) pos_z = 0;
            end
        end
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    endtask

    task automatic check_cell();
        t_cell_result want;
        if (expected_cells.size() == 0) begin
            report_mismatch("unexpected result", 72'(i_m_tdata), '0);
            return;
        end
        want = expected_cells.pop_front();
        if (i_m_tdata[34:0] !== want.diff_mag)
            report_mismatch("diff_magnitude", 72'(i_m_tdata[34:0]), 72'(want.diff_mag));
        if (i_m_tdata[70:35] !== want.mean_val)
            report_mismatch("mean_value", 72'(i_m_tdata[70:35]), 72'(want.mean_val));
        if (i_m_tuser !== want.mean_vld)
            report_mismatch("mean_valid", 72'(i_m_tuser), 72'(want.mean_vld));
        if (i_m_tdata[76:71] !== want.cx)
            report_mismatch("cell_x", 72'(i_m_tdata[76:71]), 72'(want.cx));
        if (i_m_tdata[82:77] !== want.cy)
            report_mismatch("cell_y", 72'(i_m_tdata[82:77]), 72'(want.cy));
        if (i_m_tdata[88:83] !== want.cz)
            report_mismatch("cell_z", 72'(i_m_tdata[88:83]), 72'(want.cz));
        if (i_m_tdata[95:89] !== 7'd0)
            report_mismatch("pad bits", 72'(i_m_tdata[95:89]), '0);
        if (i_m_tlast !== want.last)
            report_mismatch("last", 72'(i_m_tlast), 72'(want.last));
    endtask

    initial begin
        fail_count = 0;
        for (int i = 0; i < HIST_DEPTH; i++) sample_hist[i] = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr    = 0;
            pos_x     = 0; pos_y = 0; pos_z = 0;
            dims_r    = 2'd3;
            size_x_r  = 7'd64; size_y_r = 7'd64; size_z_r = 7'd64;
            mean_en_r = 1'b1;
        end else begin
            if (i_m_tvalid && i_m_tready) check_cell();
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_DIMENSIONS:  dims_r    = i_pwdata[1:0];
                    REG_SIZE_X:      size_x_r  = i_pwdata[6:0];
                    REG_SIZE_Y:      size_y_r  = i_pwdata[6:0];
                    REG_SIZE_Z:      size_z_r  = i_pwdata[6:0];
                    REG_MEAN_ENABLE: mean_en_r = i_pwdata[0];
                    default: ;
                endcase
                if (i_paddr[4:2] <= REG_MEAN_ENABLE) begin
                    pos_x = 0; pos_y = 0; pos_z = 0;
                end
            end
            if (i_s_tvalid && i_s_tready) predict_cell(i_s_tdata);
        end
    end

endmodule

// ----- sim/second_difference_magnitude_stencil_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_difference_magnitude_stencil_tb
// Drives grids of 1D, 2D and 3D shapes through the stencil with bursty input
// and a stalling output, rewriting the registers between grids; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module second_difference_magnitude_stencil_tb;
    import sdms_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser, m_tlast;
    int          fail_count, pending;
    int          burst_left;
    int          stall_mode, stall_left;

    second_difference_magnitude_stencil DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    second_difference_magnitude_stencil_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: long ready stretches, random stalls, and long holds
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
            m_tready   <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(signed'($urandom_range(0, 511)) - 256);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_grid(input logic [1:0] dims, input logic [6:0] sx,
                            input logic [6:0] sy, input logic [6:0] sz,
                            input logic me, input int count);
        wait_drained();
        reg_write(REG_DIMENSIONS, 32'(dims));
        reg_write(REG_SIZE_X, 32'(sx));
        reg_write(REG_SIZE_Y, 32'(sy));
        reg_write(REG_SIZE_Z, 32'(sz));
        reg_write(REG_MEAN_ENABLE, 32'(me));
        for (int i = 0; i < count; i++) send_sample(pick_sample());
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [31:0] extremes[12];
        extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        s_tvalid <= 1'b0; s_tdata <= '0; m_tready <= 1'b0;
        stall_mode = 0; stall_left = 0; burst_left = 0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes through the smallest 1D row
        wait_drained();
        reg_write(REG_DIMENSIONS, 32'd1);
        reg_write(REG_SIZE_X, 32'd3);
        reg_write(REG_MEAN_ENABLE, 32'd1);
        foreach (extremes[i]) send_sample(extremes[i]);
        s_tvalid <= 1'b0;
        // index past the register list: no effect
        wait_drained();
        reg_write(t_reg_idx'(3'd5), 32'hFFFF_FFFF);

        run_grid(2'd0, 7'd0, 7'd5, 7'd5, 1'b0, 6);     // zero dims, size_x clamped up
        run_grid(2'd2, 7'd4, 7'd2, 7'd1, 1'b1, 8);     // grid too thin, no results
        run_grid(2'd3, 7'd5, 7'd5, 7'd2, 1'b1, 7);     // too thin in z

        // random part
        run_grid(2'd2, 7'd5, 7'd4, 7'd0, 1'b1, 40);
        run_grid(2'd3, 7'd3, 7'd3, 7'd3, 1'b1, 54);
        run_grid(2'd3, 7'd4, 7'd4, 7'd3, 1'b0, 60);
        run_grid(2'd1, 7'd127, 7'd0, 7'd0, 1'b1, 70);  // size_x clamped to max
        run_grid(2'd2, 7'd3, 7'd64, 7'd3, 1'b0, 80);
        run_grid(2'd3, 7'd3, 7'd3, 7'd64, 1'b1, 60);
        for (int p = 0; p < 2; p++)
            run_grid(2'($urandom_range(0, 3)), 7'($urandom_range(0, 7)),
                     7'($urandom_range(1, 6)), 7'($urandom_range(1, 5)),
                     1'($urandom_range(0, 1)), $urandom_range(10, 20));

        wait_drained();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sdms_pkg.sv
rtl/sdms_delay.sv
rtl/sdms_front.sv
rtl/sdms_fifo.sv
rtl/sdms_isqrt.sv
rtl/sdms_back.sv
rtl/second_difference_magnitude_stencil.sv
sim/second_difference_magnitude_stencil_checker.sv
sim/second_difference_magnitude_stencil_tb.sv
